/* rtl/lsr_pkg.sv */
// Shared types and constants of the label select and relabel engine.
package lsr_pkg;

	localparam int unsigned LABEL_W = 16;
	localparam int unsigned MASK_W  = 8;
	localparam int unsigned ENTRY_W = 8;

	localparam logic [ENTRY_W-1:0] CONFLICT_VALUE = 8'd255;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_MARK  = 2'd1,
		OP_LEARN = 2'd2,
		OP_APPLY = 2'd3
	} op_t;

	typedef enum logic {
		CFG_INVERT   = 1'b0,
		CFG_SET_MODE = 1'b1
	} cfg_index_t;

endpackage

/* rtl/lsr_mem.sv */
// Label table memory with one write port and one registered read port.
module lsr_mem #(
	parameter int unsigned ADDR_BITS = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_BITS-1:0]        waddr,
	input  logic [lsr_pkg::ENTRY_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_BITS-1:0]        raddr,
	output logic [lsr_pkg::ENTRY_W-1:0] rdata
);
	import lsr_pkg::*;

	logic [ENTRY_W-1:0] mem [2**ADDR_BITS];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/lsr_sweep.sv */
// Fill sequencer that walks every table entry after reset and on a clear.
module lsr_sweep #(
	parameter int unsigned ADDR_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fill_start,
	input  logic                        fill_bit,
	output logic                        active,
	output logic [ADDR_BITS-1:0]        addr,
	output logic [lsr_pkg::ENTRY_W-1:0] data
);
	import lsr_pkg::*;

	logic                 active_q;
	logic [ADDR_BITS-1:0] cnt_q;
	logic                 fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
			fill_q   <= 1'b0;
		end else if (fill_start) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
			fill_q   <= fill_bit;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {ADDR_BITS{1'b1}}) begin
				active_q <= 1'b0;
			end
		end
	end

	assign active = active_q;
	assign addr   = cnt_q;
	assign data   = ENTRY_W'(fill_q);

endmodule

/* rtl/label_select_relabel_top.sv */
// Top level of the label select and relabel engine.
// One item is accepted per cycle while busy is low; an apply result is registered in out_value
// with done high for one cycle, after the item has passed the s1 stage registers and the done
// register, and cannot be held off.
// The table is one memory of 2^LABEL_BITS entries read and written back in a single stage, with
// forwarding between neighboring items. After reset, and after each clear, a fill pass writes
// one entry per cycle, so busy stays high after reset until the pass ends, and after a clear is
// accepted it stays high while the clear sits in s1 and then through the whole pass.
module label_select_relabel_top #(
	parameter int unsigned LABEL_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  op,
	input  logic [lsr_pkg::LABEL_W-1:0] label,
	input  logic [lsr_pkg::MASK_W-1:0]  mask_value,
	output logic                        done,
	output logic [lsr_pkg::LABEL_W-1:0] out_value,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic                        cfg_wdata
);
	import lsr_pkg::*;

	logic                  accept;
	logic [LABEL_BITS-1:0] lab_in;

	logic                  invert_q;
	logic                  set_mode_q;

	logic                  valid_s1;
	op_t                   op_s1;
	logic [LABEL_BITS-1:0] lab_s1;
	logic [MASK_W-1:0]     mval_s1;
	logic                  fwd_s1;
	logic [ENTRY_W-1:0]    fwd_data_s1;

	logic [ENTRY_W-1:0]    rd_data;
	logic [ENTRY_W-1:0]    entry;
	logic [ENTRY_W-1:0]    keep;
	logic                  upd_we;
	logic [ENTRY_W-1:0]    upd_data;
	logic                  res_valid;
	logic [LABEL_W-1:0]    res_value;

	logic                  sweep_active;
	logic [LABEL_BITS-1:0] sweep_addr;
	logic [ENTRY_W-1:0]    sweep_data;
	logic                  clear_s1;

	logic                  mem_we;
	logic [LABEL_BITS-1:0] mem_waddr;
	logic [ENTRY_W-1:0]    mem_wdata;

	logic                  done_q;
	logic [LABEL_W-1:0]    out_value_q;

	assign lab_in   = label[LABEL_BITS-1:0];
	assign clear_s1 = valid_s1 && (op_s1 == OP_CLEAR);
	assign busy     = sweep_active || clear_s1;
	assign accept   = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q   <= 1'b0;
			set_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_INVERT:   invert_q   <= cfg_wdata;
				CFG_SET_MODE: set_mode_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_q   <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_t'(op);
			lab_s1      <= lab_in;
			mval_s1     <= mask_value;
			fwd_s1      <= upd_we && (lab_s1 == lab_in);
			fwd_data_s1 <= upd_data;
		end
		if (res_valid) begin
			out_value_q <= res_value;
		end
	end

	assign entry = fwd_s1 ? fwd_data_s1 : rd_data;
	assign keep  = invert_q ? ENTRY_W'(0) : ENTRY_W'(1);

	always_comb begin
		upd_we    = 1'b0;
		upd_data  = keep;
		res_valid = 1'b0;
		res_value = '0;
		if (valid_s1) begin
			unique case (op_s1)
				OP_CLEAR: ;
				OP_MARK: begin
					upd_we = 1'b1;
				end
				OP_LEARN: begin
					if (mval_s1 != '0) begin
						if (!set_mode_q) begin
							upd_we = 1'b1;
						end else if (lab_s1 != '0) begin
							upd_we = 1'b1;
							if (entry == '0 || entry == mval_s1) begin
								upd_data = mval_s1;
							end else begin
								upd_data = CONFLICT_VALUE;
							end
						end
					end
				end
				OP_APPLY: begin
					res_valid = 1'b1;
					if (set_mode_q) begin
						res_value = LABEL_W'(entry);
					end else if (entry != '0) begin
						res_value = LABEL_W'(lab_s1);
					end
				end
				default: ;
			endcase
		end
	end

	lsr_sweep #(
		.ADDR_BITS(LABEL_BITS)
	) u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.fill_start(clear_s1),
		.fill_bit  (invert_q),
		.active    (sweep_active),
		.addr      (sweep_addr),
		.data      (sweep_data)
	);

	assign mem_we    = sweep_active || upd_we;
	assign mem_waddr = sweep_active ? sweep_addr : lab_s1;
	assign mem_wdata = sweep_active ? sweep_data : upd_data;

	lsr_mem #(
		.ADDR_BITS(LABEL_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(lab_in),
		.rdata(rd_data)
	);

	assign done      = done_q;
	assign out_value = out_value_q;

`ifndef ASSERT_OFF
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep_active && upd_we))
		else $error("Fill pass and table update write in the same cycle.");

	a_clear_starts_fill: assert property (@(posedge clk) disable iff (!arst_n)
		clear_s1 |=> sweep_active)
		else $error("A clear did not start the fill pass.");

	a_done_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1 && op_s1 == OP_APPLY))
		else $error("A result beat appeared without an apply item.");

	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_active |=> !valid_s1 || $past(!sweep_active))
		else $error("An item was accepted during the fill pass.");
`endif

endmodule

/* tb/testbench.sv */
// Testbench for the label select and relabel engine: scoreboard, stimulus and checks.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lsr_pkg::*;

	localparam int unsigned LABEL_BITS  = 16;
	localparam int unsigned TABLE_DEPTH = 1 << LABEL_BITS;
	localparam int unsigned PHASE_ITEMS = 320;
	localparam int unsigned STALL_LIMIT = 200000;

	class relabel_scoreboard;
		bit [ENTRY_W-1:0] entries [0:TABLE_DEPTH-1];
		bit invert;
		bit set_mode;
		logic [LABEL_W-1:0] out_q [$];
		int errors;

		function void reset_state();
			foreach (entries[i]) entries[i] = '0;
			invert = 1'b0;
			set_mode = 1'b0;
		endfunction

		function void write_reg(cfg_index_t idx, bit value);
			if (idx == CFG_INVERT) begin
				invert = value;
			end else begin
				set_mode = value;
			end
		endfunction

		function void note_item(op_t o, logic [LABEL_W-1:0] lab_in, logic [MASK_W-1:0] mval);
			logic [LABEL_W-1:0] lab;
			bit [ENTRY_W-1:0] keep;
			bit [ENTRY_W-1:0] entry;
			lab = lab_in & LABEL_W'(TABLE_DEPTH - 1);
			keep = invert ? '0 : ENTRY_W'(1);
			entry = entries[lab];
			case (o)
				OP_CLEAR: begin
					foreach (entries[i]) entries[i] = ENTRY_W'(invert);
				end
				OP_MARK: begin
					entries[lab] = keep;
				end
				OP_LEARN: begin
					if (mval != '0) begin
						if (!set_mode) begin
							entries[lab] = keep;
						end else if (lab != '0) begin
							if (entry == '0 || entry == mval) entries[lab] = mval;
							else entries[lab] = CONFLICT_VALUE;
						end
					end
				end
				default: begin
					if (set_mode) out_q.push_back(LABEL_W'(entry));
					else out_q.push_back((entry == '0) ? '0 : lab);
				end
			endcase
		endfunction

		function void check_value(logic [LABEL_W-1:0] got);
			logic [LABEL_W-1:0] want;
			if (out_q.size() == 0) begin
				errors++;
				$display("%0t: out_value expected none, actual %h", $time, got);
			end else begin
				want = out_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: out_value expected %h, actual %h", $time, want, got);
				end
			end
		endfunction

		function int pending();
			return out_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] op;
	logic [LABEL_W-1:0] label;
	logic [MASK_W-1:0] mask_value;
	logic done;
	logic [LABEL_W-1:0] out_value;
	logic cfg_we;
	logic cfg_index;
	logic cfg_wdata;

	relabel_scoreboard sb;
	int unsigned idle_cycles = 0;

	label_select_relabel_top #(
		.LABEL_BITS(LABEL_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.label(label),
		.mask_value(mask_value),
		.done(done),
		.out_value(out_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (done === 1'b1) sb.check_value(out_value);
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(op_t o, logic [LABEL_W-1:0] lab, logic [MASK_W-1:0] mv);
		start <= 1'b1;
		op <= o;
		label <= lab;
		mask_value <= mv;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(o, lab, mv);
	endtask

	task automatic pause(int unsigned n);
		start <= 1'b0;
		op <= 2'($urandom);
		label <= LABEL_W'($urandom);
		mask_value <= MASK_W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	task automatic write_cfg(bit inv, bit sm);
		drain();
		repeat (4) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_INVERT;
		cfg_wdata <= inv;
		@(posedge clk);
		sb.write_reg(CFG_INVERT, inv);
		cfg_index <= CFG_SET_MODE;
		cfg_wdata <= sm;
		@(posedge clk);
		sb.write_reg(CFG_SET_MODE, sm);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(bit inv, bit sm, bit gaps);
		logic [LABEL_W-1:0] pool [12];
		logic [MASK_W-1:0] masks [4];
		logic [LABEL_W-1:0] lab;
		logic [MASK_W-1:0] mv;
		int unsigned burst;
		int unsigned pick;
		op_t o;
		write_cfg(inv, sm);
		pool[0] = '0;
		pool[1] = '1;
		for (int i = 2; i < 12; i++) pool[i] = LABEL_W'($urandom);
		masks[0] = CONFLICT_VALUE;
		for (int i = 1; i < 4; i++) masks[i] = MASK_W'($urandom_range(1, 255));
		send_item(OP_CLEAR, LABEL_W'($urandom), MASK_W'($urandom));
		burst = $urandom_range(1, 24);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (n == PHASE_ITEMS / 2) drain();
			pick = $urandom_range(0, 99);
			if (pick < 15) o = OP_MARK;
			else if (pick < 55) o = OP_LEARN;
			else o = OP_APPLY;
			lab = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 11)]
				: LABEL_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 20) mv = '0;
			else if (pick < 70) mv = masks[$urandom_range(0, 3)];
			else mv = MASK_W'($urandom);
			send_item(o, lab, mv);
			if (gaps) begin
				burst--;
				if (burst == 0) begin
					pause($urandom_range(1, 6));
					burst = $urandom_range(1, 24);
				end
			end
		end
	endtask

	initial begin
		sb = new;
		sb.reset_state();
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_CLEAR;
		label <= '0;
		mask_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_INVERT;
		cfg_wdata <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Select mode, keep marked labels; back-to-back beats exercise forwarding.
		write_cfg(1'b0, 1'b0);
		send_item(OP_APPLY, 16'h0000, 8'h00);
		send_item(OP_APPLY, 16'hFFFF, 8'hFF);
		send_item(OP_MARK, 16'hFFFF, 8'h00);
		send_item(OP_APPLY, 16'hFFFF, 8'h00);
		send_item(OP_MARK, 16'h0000, 8'hFF);
		send_item(OP_APPLY, 16'h0000, 8'h00);
		send_item(OP_LEARN, 16'h1234, 8'h00);
		send_item(OP_APPLY, 16'h1234, 8'h00);
		send_item(OP_LEARN, 16'hABCD, 8'hFF);
		send_item(OP_APPLY, 16'hABCD, 8'h00);
		send_item(OP_LEARN, 16'h5555, 8'hAA);
		send_item(OP_APPLY, 16'hAAAA, 8'h55);

		// Inverted select mode: a clear keeps everything, marks and learns drop labels.
		write_cfg(1'b1, 1'b0);
		send_item(OP_CLEAR, 16'h0000, 8'h00);
		send_item(OP_APPLY, 16'h0777, 8'h00);
		send_item(OP_MARK, 16'h0777, 8'h00);
		send_item(OP_LEARN, 16'h0999, 8'h01);
		send_item(OP_APPLY, 16'h0777, 8'h00);
		send_item(OP_APPLY, 16'h0999, 8'h00);

		// Set mode: label zero ignored, repeated value kept, differing value conflicts.
		write_cfg(1'b0, 1'b1);
		send_item(OP_CLEAR, 16'hFFFF, 8'hFF);
		send_item(OP_LEARN, 16'h0000, 8'h05);
		send_item(OP_APPLY, 16'h0000, 8'h00);
		send_item(OP_LEARN, 16'h0064, 8'h07);
		send_item(OP_LEARN, 16'h0064, 8'h07);
		send_item(OP_APPLY, 16'h0064, 8'h00);
		send_item(OP_LEARN, 16'h0064, 8'h08);
		send_item(OP_APPLY, 16'h0064, 8'h00);
		send_item(OP_MARK, 16'h012C, 8'h00);
		send_item(OP_APPLY, 16'h012C, 8'h00);

		random_phase(1'b0, 1'b0, 1'b1);
		random_phase(1'b1, 1'b0, 1'b1);
		random_phase(1'b0, 1'b1, 1'b0);
		random_phase(1'b1, 1'b1, 1'b1);
		random_phase(1'b0, 1'b1, 1'b1);
		random_phase(1'($urandom), 1'($urandom), 1'b1);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
